@@ rtl/dstoi_pkg.sv @@
// shared constants, types and helpers of the decimal string to int64 parser
package dstoi_pkg;

  localparam int MAX_LEN = 4096;
  localparam int POS_W   = $clog2(MAX_LEN + 1);
  localparam int CHAR_W  = 8;
  localparam int VALUE_W = 64;
  localparam int END_W   = 13;
  localparam int ACC_W   = VALUE_W + 4;

  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_VT    = 8'h0B;
  localparam logic [CHAR_W-1:0] CH_FF    = 8'h0C;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

  localparam logic [VALUE_W-1:0] MAG_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [VALUE_W-1:0] MAG_MIN = 64'h8000_0000_0000_0000;

  typedef enum logic [1:0] {
    PH_DONE,
    PH_WS,
    PH_SIGN,
    PH_DIG
  } phase_t;

  typedef struct packed {
    logic [CHAR_W-1:0] char_byte;
    logic              string_start;
  } item_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic [END_W-1:0]          end_offset;
    logic                      overflowed;
  } res_t;

  function automatic logic is_space(input logic [CHAR_W-1:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) ||
           (c == CH_CR) || (c == CH_VT) || (c == CH_FF);
  endfunction

  function automatic logic is_digit(input logic [CHAR_W-1:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

endpackage

@@ rtl/dstoi_ifs.sv @@
// character and result channel interfaces
interface dstoi_char_if import dstoi_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_byte;
  logic              string_start;

  modport source(output valid, output char_byte, output string_start, input ready);
  modport sink(input valid, input char_byte, input string_start, output ready);
endinterface

interface dstoi_res_if import dstoi_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value;
  logic [END_W-1:0]          end_offset;
  logic                      overflowed;

  modport source(output valid, output value, output end_offset, output overflowed,
                 input ready);
  modport sink(input valid, input value, input end_offset, input overflowed,
               output ready);
endinterface

@@ rtl/dstoi_parse.sv @@
// parse state machine: whitespace, sign and saturating digit accumulation
module dstoi_parse import dstoi_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  go,
  input  item_t item,
  output logic  res_valid,
  output res_t  res
);

  phase_t             phase, phase_next;
  logic               is_negative, is_negative_next;
  logic [VALUE_W-1:0] magnitude, magnitude_next;
  logic               clipped, clipped_next;
  logic [POS_W-1:0]   position, position_next;
  logic [POS_W-1:0]   digits_begin, digits_begin_next;

  phase_t             cur_phase;
  logic               cur_neg;
  logic [VALUE_W-1:0] cur_mag;
  logic               cur_clip;
  logic [POS_W-1:0]   cur_pos;
  logic [POS_W-1:0]   cur_db;
  logic [POS_W-1:0]   pos_inc;
  logic               c_space, c_sign, c_digit;
  logic               ws_eaten, take, emit, no_digits;
  logic [ACC_W-1:0]   acc, bound;
  logic               over;

  // a string start restarts the parse with this character
  assign cur_phase = item.string_start ? PH_WS : phase;
  assign cur_neg   = item.string_start ? 1'b0 : is_negative;
  assign cur_mag   = item.string_start ? '0 : magnitude;
  assign cur_clip  = item.string_start ? 1'b0 : clipped;
  assign cur_pos   = item.string_start ? '0 : position;
  assign cur_db    = item.string_start ? '0 : digits_begin;

  assign pos_inc = (cur_pos >= POS_W'(MAX_LEN)) ? POS_W'(MAX_LEN) : cur_pos + 1'b1;

  assign c_space = is_space(item.char_byte);
  assign c_sign  = (item.char_byte == CH_PLUS) || (item.char_byte == CH_MINUS);
  assign c_digit = is_digit(item.char_byte);

  assign ws_eaten  = (cur_phase == PH_WS) && (c_space || c_sign);
  assign take      = (cur_phase != PH_DONE) && !ws_eaten && c_digit;
  assign emit      = (cur_phase != PH_DONE) && !ws_eaten && !c_digit;
  assign no_digits = (cur_phase == PH_SIGN) || (cur_phase == PH_WS);

  // magnitude * 10 + digit against the bound for the sign
  assign acc   = (ACC_W'(cur_mag) << 3) + (ACC_W'(cur_mag) << 1) +
                 ACC_W'(item.char_byte[3:0]);
  assign bound = ACC_W'(MAG_MAX) + ACC_W'(cur_neg);
  assign over  = acc > bound;

  always_comb begin
    phase_next = cur_phase;
    unique case (cur_phase)
      PH_DONE: phase_next = PH_DONE;
      PH_WS: begin
        if (c_space) begin
          phase_next = PH_WS;
        end else if (c_sign) begin
          phase_next = PH_SIGN;
        end else if (c_digit) begin
          phase_next = PH_DIG;
        end else begin
          phase_next = PH_DONE;
        end
      end
      PH_SIGN, PH_DIG: phase_next = c_digit ? PH_DIG : PH_DONE;
      default: phase_next = PH_DONE;
    endcase
  end

  always_comb begin
    is_negative_next  = cur_neg;
    magnitude_next    = cur_mag;
    clipped_next      = cur_clip;
    position_next     = cur_pos;
    digits_begin_next = cur_db;
    if (cur_phase == PH_WS) begin
      if (c_space) begin
        position_next = pos_inc;
      end else if (c_sign) begin
        is_negative_next  = (item.char_byte == CH_MINUS);
        position_next     = pos_inc;
        digits_begin_next = pos_inc;
      end else begin
        digits_begin_next = cur_pos;
      end
    end
    if (take) begin
      position_next = pos_inc;
      if (!cur_clip) begin
        if (over) begin
          magnitude_next = bound[VALUE_W-1:0];
          clipped_next   = 1'b1;
        end else begin
          magnitude_next = acc[VALUE_W-1:0];
        end
      end
    end
  end

  always_comb begin
    res_valid = go && emit;
    if (no_digits) begin
      res.value      = '0;
      res.end_offset = END_W'((cur_phase == PH_SIGN) ? cur_db : cur_pos);
      res.overflowed = 1'b0;
    end else begin
      res.value      = $signed(cur_neg ? (VALUE_W'(0) - cur_mag) : cur_mag);
      res.end_offset = END_W'(cur_pos);
      res.overflowed = cur_clip;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_DONE;
      is_negative  <= 1'b0;
      clipped      <= 1'b0;
      position     <= '0;
      digits_begin <= '0;
    end else if (go) begin
      phase        <= phase_next;
      is_negative  <= is_negative_next;
      clipped      <= clipped_next;
      position     <= position_next;
      digits_begin <= digits_begin_next;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      magnitude <= magnitude_next;
    end
  end

  a_clip_at_bound: assert property (@(posedge clk) disable iff (rst)
    clipped |-> (magnitude == MAG_MAX || magnitude == MAG_MIN))
    else $error("clipped magnitude off its bound");

  a_pos_limit: assert property (@(posedge clk) disable iff (rst)
    position <= POS_W'(MAX_LEN))
    else $error("position beyond limit");

  a_db_order: assert property (@(posedge clk) disable iff (rst)
    digits_begin <= position)
    else $error("digit start after current position");

endmodule

@@ rtl/decimal_string_to_int64_saturating.sv @@
// top level: input register, parse stage and two-entry result buffer
// the ending character sits in the input register; its result is registered in the buffer
// throughput: one character per cycle; the result buffer holds two results, so characters
// keep flowing while a result waits, and input stalls only when both entries and the
// input register are full
// reset: synchronous rst clears the pipeline valids and leaves the parser idle until a string start
module decimal_string_to_int64_saturating import dstoi_pkg::*; (
  input logic         clk,
  input logic         rst,
  dstoi_char_if.sink  chars,
  dstoi_res_if.source results
);

  logic  s1_valid;
  item_t s1_item;
  logic  proc_go;
  logic  p_valid;
  res_t  p_res;
  logic  out_valid, skid_valid;
  res_t  out_res, skid_res;
  logic  out_take;

  assign proc_go     = s1_valid && !skid_valid;
  assign chars.ready = !s1_valid || !skid_valid;
  assign out_take    = out_valid && results.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (chars.ready) begin
      s1_valid <= chars.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (chars.valid && chars.ready) begin
      s1_item.char_byte    <= chars.char_byte;
      s1_item.string_start <= chars.string_start;
    end
  end

  dstoi_parse u_parse (
    .clk       (clk),
    .rst       (rst),
    .go        (proc_go),
    .item      (s1_item),
    .res_valid (p_valid),
    .res       (p_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_take) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (p_valid) begin
      if (out_valid && !results.ready) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_take) begin
        out_res <= skid_res;
      end
    end else if (p_valid) begin
      if (out_valid && !results.ready) begin
        skid_res <= p_res;
      end else begin
        out_res <= p_res;
      end
    end
  end

  assign results.valid      = out_valid;
  assign results.value      = out_res.value;
  assign results.end_offset = out_res.end_offset;
  assign results.overflowed = out_res.overflowed;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry without output entry");

  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(out_valid && !results.ready))
    else $error("skid filled while output was free");

  a_ovf_value: assert property (@(posedge clk) disable iff (rst)
    (results.valid && results.overflowed) |->
      (results.value == $signed(MAG_MAX) || results.value == $signed(MAG_MIN)))
    else $error("overflowed result not at an int64 limit");

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// self-checking testbench of the decimal string to int64 parser with a scoreboard of conversions
module testbench;
  import dstoi_pkg::*;

  typedef enum {RX_FREE, RX_COIN, RX_PATTERN} rx_mode_t;

  localparam int N_DIRECTED = 10;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 8;

  logic clk;
  logic rst;

  dstoi_char_if chars_if ();
  dstoi_res_if  res_if ();

  decimal_string_to_int64_saturating i_dut (
    .clk     (clk),
    .rst     (rst),
    .chars   (chars_if),
    .results (res_if)
  );

  // parser state mirrored by the scoreboard
  phase_t           scan_phase;
  logic             scan_neg;
  logic [VALUE_W-1:0] scan_mag;
  logic             scan_clip;
  logic [END_W-1:0] scan_pos;
  logic [END_W-1:0] scan_digits_at;

  res_t pending_conversions [$];
  int   mismatches;
  int   live_items;
  int   burst_left;
  bit   hold_request;
  logic next_start;

  logic [CHAR_W-1:0] ws_chars [6] = '{CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR};

  // directed strings: text, start mark, NUL appended, typed expectation
  string dir_text [N_DIRECTED] = '{
    "55",
    "",
    "9223372036854775807",
    "-9223372036854775808",
    "92233720368547758089",
    "-92233720368547758090",
    "\011\012\013\014\015 +x",
    "  -42a7",
    "123",
    "0"
  };
  bit dir_start [N_DIRECTED] = '{0, 1, 1, 1, 1, 1, 1, 1, 1, 1};
  bit dir_nul   [N_DIRECTED] = '{0, 1, 1, 1, 1, 1, 1, 1, 0, 1};
  bit dir_typed [N_DIRECTED] = '{0, 1, 1, 1, 1, 1, 1, 0, 0, 0};
  res_t dir_result [N_DIRECTED] = '{
    '{64'sd0, 13'd0, 1'b0},
    '{64'sd0, 13'd0, 1'b0},
    '{MAG_MAX, 13'd19, 1'b0},
    '{MAG_MIN, 13'd20, 1'b0},
    '{MAG_MAX, 13'd20, 1'b1},
    '{MAG_MIN, 13'd21, 1'b1},
    '{64'sd0, 13'd7, 1'b0},
    '{64'sd0, 13'd0, 1'b0},
    '{64'sd0, 13'd0, 1'b0},
    '{64'sd0, 13'd0, 1'b0}
  };

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [END_W-1:0] bump_pos(input logic [END_W-1:0] p);
    return (p >= END_W'(MAX_LEN)) ? END_W'(MAX_LEN) : p + 1'b1;
  endfunction

  function automatic logic [CHAR_W-1:0] any_non_digit();
    logic [CHAR_W-1:0] c;
    do c = CHAR_W'($urandom); while (c >= CH_ZERO && c <= CH_NINE);
    return c;
  endfunction

  function automatic logic [CHAR_W-1:0] any_digit();
    return CH_ZERO + CHAR_W'($urandom_range(0, 9));
  endfunction

  task automatic convert_char(input logic [CHAR_W-1:0] c, input logic s,
                              output bit done, output bit live, output res_t r);
    logic [VALUE_W-1:0] d;
    logic [VALUE_W-1:0] bound;
    done = 1'b0;
    live = 1'b0;
    r = '0;
    if (s) begin
      scan_phase = PH_WS;
      scan_neg = 1'b0;
      scan_mag = '0;
      scan_clip = 1'b0;
      scan_pos = '0;
      scan_digits_at = '0;
    end
    if (scan_phase == PH_DONE) return;
    live = 1'b1;
    if (scan_phase == PH_WS) begin
      if (c inside {CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR}) begin
        scan_pos = bump_pos(scan_pos);
        return;
      end
      if (c == CH_PLUS || c == CH_MINUS) begin
        scan_neg = (c == CH_MINUS);
        scan_pos = bump_pos(scan_pos);
        scan_digits_at = scan_pos;
        scan_phase = PH_SIGN;
        return;
      end
      scan_digits_at = scan_pos;
      scan_phase = PH_SIGN;
    end
    if (c >= CH_ZERO && c <= CH_NINE) begin
      d = VALUE_W'(c - CH_ZERO);
      bound = scan_neg ? MAG_MIN : MAG_MAX;
      if (!scan_clip) begin
        if (scan_mag > (bound - d) / 10) begin
          scan_mag = bound;
          scan_clip = 1'b1;
        end else begin
          scan_mag = scan_mag * 10 + d;
        end
      end
      scan_pos = bump_pos(scan_pos);
      scan_phase = PH_DIG;
      return;
    end
    done = 1'b1;
    if (scan_phase == PH_SIGN) begin
      r.value = '0;
      r.end_offset = scan_digits_at;
      r.overflowed = 1'b0;
    end else begin
      r.value = scan_neg ? -scan_mag : scan_mag;
      r.end_offset = scan_pos;
      r.overflowed = scan_clip;
    end
    scan_phase = PH_DONE;
  endtask

  task automatic send_char(input logic [CHAR_W-1:0] c, input logic s,
                           input bit fixed, input res_t fixed_res);
    int   gap;
    bit   done;
    bit   live;
    res_t r;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 24);
      if (gap != 0) begin
        chars_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    chars_if.valid <= 1'b1;
    chars_if.char_byte <= c;
    chars_if.string_start <= s;
    do @(posedge clk); while (!chars_if.ready);
    burst_left--;
    convert_char(c, s, done, live, r);
    if (live) live_items++;
    if (done) pending_conversions.push_back(fixed ? fixed_res : r);
  endtask

  task automatic put(input logic [CHAR_W-1:0] c);
    send_char(c, next_start, 1'b0, '0);
    next_start = 1'b0;
  endtask

  task automatic send_number(input bit terminate);
    string prefix;
    int    n;
    int    style;
    prefix = "922337203685477580";
    next_start = 1'b1;
    n = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 3);
    repeat (n) put(ws_chars[$urandom_range(0, 5)]);
    case ($urandom_range(0, 2))
      1: put(CH_PLUS);
      2: put(CH_MINUS);
      default: ;
    endcase
    style = $urandom_range(0, 9);
    if (style < 4) begin
      repeat ($urandom_range(1, 4)) put(any_digit());
    end else if (style < 6) begin
      repeat ($urandom_range(5, 18)) put(any_digit());
    end else if (style < 8) begin
      for (int k = 0; k < prefix.len(); k++) put(prefix[k]);
      put(any_digit());
      repeat ($urandom_range(0, 2)) put(any_digit());
    end else if (style == 8) begin
      repeat ($urandom_range(20, 24)) put(any_digit());
    end
    if (terminate) begin
      put(($urandom_range(0, 9) < 7) ? 8'h00 : any_non_digit());
      repeat ($urandom_range(0, 2)) put(CHAR_W'($urandom));
    end
  endtask

  task automatic wait_drained();
    chars_if.valid <= 1'b0;
    while (pending_conversions.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic check_result();
    res_t want;
    if (pending_conversions.size() == 0) begin
      $error("result with no conversion pending: value %0d end_offset %0d overflowed %0d",
             res_if.value, res_if.end_offset, res_if.overflowed);
      mismatches++;
      return;
    end
    want = pending_conversions.pop_front();
    if (res_if.value !== want.value) begin
      $error("value: expected %0d, got %0d", want.value, res_if.value);
      mismatches++;
    end
    if (res_if.end_offset !== want.end_offset) begin
      $error("end_offset: expected %0d, got %0d", want.end_offset, res_if.end_offset);
      mismatches++;
    end
    if (res_if.overflowed !== want.overflowed) begin
      $error("overflowed: expected %0d, got %0d", want.overflowed, res_if.overflowed);
      mismatches++;
    end
  endtask

  // result sink with its own stall pattern and a long hold-off on request
  initial begin
    rx_mode_t mode;
    int       cyc;
    int       hold_left;
    logic     rdy;
    mode = RX_FREE;
    cyc = 0;
    hold_left = 0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && res_if.valid && res_if.ready) check_result();
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else begin
        if (cyc % 64 == 0) mode = rx_mode_t'($urandom_range(0, 2));
        case (mode)
          RX_FREE: rdy = 1'b1;
          RX_COIN: rdy = 1'($urandom_range(0, 1));
          default: rdy = (cyc % 7) >= 3;
        endcase
      end
      res_if.ready <= rdy;
      cyc++;
    end
  end

  // stimulus
  initial begin
    logic first;
    int   strings;
    scan_phase = PH_DONE;
    scan_neg = 1'b0;
    scan_mag = '0;
    scan_clip = 1'b0;
    scan_pos = '0;
    scan_digits_at = '0;
    mismatches = 0;
    live_items = 0;
    burst_left = 0;
    hold_request = 1'b0;
    next_start = 1'b0;
    rst <= 1'b1;
    chars_if.valid <= 1'b0;
    chars_if.char_byte <= '0;
    chars_if.string_start <= 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    for (int r = 0; r < N_DIRECTED; r++) begin
      first = dir_start[r];
      for (int k = 0; k < dir_text[r].len(); k++) begin
        send_char(dir_text[r][k], first, dir_typed[r], dir_result[r]);
        first = 1'b0;
      end
      if (dir_nul[r]) send_char(8'h00, first, dir_typed[r], dir_result[r]);
    end

    live_items = 0;
    strings = 0;
    while (live_items < 1000) begin
      if (strings == 40) hold_request = 1'b1;
      if (strings == 120) wait_drained();
      case ($urandom_range(0, 9))
        7: begin
          repeat ($urandom_range(1, 8))
            send_char(CHAR_W'($urandom), ($urandom_range(0, 7) == 0), 1'b0, '0);
        end
        8: send_number(1'b0);
        9: begin
          next_start = 1'b1;
          repeat ($urandom_range(0, 2)) put(ws_chars[$urandom_range(0, 5)]);
          if ($urandom_range(0, 1)) put(($urandom_range(0, 1)) ? CH_PLUS : CH_MINUS);
          put(any_non_digit());
        end
        default: send_number(1'b1);
      endcase
      strings++;
    end

    wait_drained();
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
